// File: rtl/nnsd_pkg.sv
// Package: shared types and constants for the nearest-neighbor distance block.
package nnsd_pkg;

    localparam int MAX_ELEMENTS = 65536;
    localparam int QUEUE_DEPTH  = 4;

    localparam int VLEN_W  = 17;
    localparam int QIDX_W  = 16;
    localparam int PIXEL_W = 8;
    localparam int CIDX_W  = 16;
    localparam int DIST_W  = 32;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [VLEN_W-1:0] VLEN_RESET = 17'h10000;
    localparam logic [QIDX_W-1:0] QIDX_RESET = 16'h0000;

    localparam logic REG_VECTOR_LENGTH = 1'b0;
    localparam logic REG_QUERY_INDEX   = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_CAND  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    typedef enum logic {
        JOB_CAND  = 1'b0,
        JOB_CLEAR = 1'b1
    } t_job_kind;

    typedef struct packed {
        t_job_kind           kind;
        logic                last;
        logic [PIXEL_W-1:0]  diff;
        logic [CIDX_W-1:0]   cidx;
    } t_job;

endpackage

// File: rtl/nnsd_in_if.sv
// Interface: input item channel with valid/ready handshake.
interface nnsd_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    opcode;
    logic [nnsd_pkg::PIXEL_W-1:0]  pixel;
    logic [nnsd_pkg::CIDX_W-1:0]   candidate_index;

    modport source (output valid, output opcode, output pixel, output candidate_index,
                    input ready);
    modport sink   (input valid, input opcode, input pixel, input candidate_index,
                    output ready);
endinterface

// File: rtl/nnsd_out_if.sv
// Interface: result channel with valid/ready handshake.
interface nnsd_out_if;
    logic                          valid;
    logic                          ready;
    logic [nnsd_pkg::CIDX_W-1:0]   done_index;
    logic [nnsd_pkg::DIST_W-1:0]   distance;
    logic [nnsd_pkg::DIST_W-1:0]   best_distance;
    logic [nnsd_pkg::CIDX_W-1:0]   best_index;
    logic                          found;

    modport source (output valid, output done_index, output distance,
                    output best_distance, output best_index, output found, input ready);
    modport sink   (input valid, input done_index, input distance,
                    input best_distance, input best_index, input found, output ready);
endinterface

// File: rtl/nnsd_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module nnsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/nnsd_fifo.sv
// Short job queue between the front and back sections.
module nnsd_fifo #(
    parameter int DEPTH = nnsd_pkg::QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  nnsd_pkg::t_job                    i_push_data,
    input  logic                              i_pop,
    output logic                              o_valid,
    output nnsd_pkg::t_job                    o_head,
    output logic [$clog2(DEPTH+1)-1:0]        o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH+1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    nnsd_pkg::t_job     r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wptr, n_wptr;
    logic [PTR_W-1:0]   r_rptr, n_rptr;
    logic [CNT_W-1:0]   r_count, n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == LAST_PTR) ? '0 : r_wptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == LAST_PTR) ? '0 : r_rptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rptr];
    assign o_count = r_count;

endmodule

// File: rtl/nnsd_front.sv
// Front section: accept items, load the query store, fetch query pixels, queue jobs.
module nnsd_front #(
    parameter int MAX_ELEMENTS = nnsd_pkg::MAX_ELEMENTS,
    parameter int QUEUE_DEPTH  = nnsd_pkg::QUEUE_DEPTH
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    nnsd_in_if.sink                                    i_in,
    input  logic [$clog2(MAX_ELEMENTS+1)-1:0]          i_len,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]           i_queue_count,
    output logic                                       o_push,
    output nnsd_pkg::t_job                             o_push_data
);

    localparam int CNT_W  = $clog2(MAX_ELEMENTS+1);
    localparam int ADDR_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH+1);
    localparam int ROOM_W = QCNT_W + 1;

    logic [CNT_W-1:0]            r_lp, n_lp;
    logic [CNT_W-1:0]            r_ec, n_ec;
    logic                        r_s1_valid, n_s1_valid;
    nnsd_pkg::t_job_kind         r_s1_kind, n_s1_kind;
    logic                        r_s1_last, n_s1_last;
    logic [nnsd_pkg::PIXEL_W-1:0] r_s1_pix;
    logic [nnsd_pkg::CIDX_W-1:0] r_s1_cidx;

    logic                        accept;
    nnsd_pkg::t_opcode           op;
    logic [CNT_W-1:0]            lp_inc;
    logic [CNT_W-1:0]            ec_inc;
    logic                        ram_we;
    logic                        ram_re;
    logic [nnsd_pkg::PIXEL_W-1:0] qpix;
    logic [ROOM_W-1:0]           occupancy;

    assign occupancy  = ROOM_W'(i_queue_count) + ROOM_W'(r_s1_valid);
    assign i_in.ready = (occupancy < ROOM_W'(QUEUE_DEPTH));
    assign accept     = i_in.valid && i_in.ready;
    assign op         = nnsd_pkg::t_opcode'(i_in.opcode);
    assign lp_inc     = r_lp + CNT_W'(1);
    assign ec_inc     = r_ec + CNT_W'(1);

    always_comb begin
        n_lp       = r_lp;
        n_ec       = r_ec;
        n_s1_valid = 1'b0;
        n_s1_kind  = nnsd_pkg::JOB_CAND;
        n_s1_last  = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        if (accept) begin
            unique case (op)
                nnsd_pkg::OP_LOAD: begin
                    ram_we = 1'b1;
                    n_lp   = (lp_inc >= i_len) ? '0 : lp_inc;
                end
                nnsd_pkg::OP_CAND: begin
                    ram_re     = 1'b1;
                    n_s1_valid = 1'b1;
                    n_s1_last  = (ec_inc >= i_len);
                    n_ec       = n_s1_last ? '0 : ec_inc;
                end
                nnsd_pkg::OP_CLEAR: begin
                    n_s1_valid = 1'b1;
                    n_s1_kind  = nnsd_pkg::JOB_CLEAR;
                    n_lp       = '0;
                    n_ec       = '0;
                end
                nnsd_pkg::OP_NOP: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp       <= '0;
            r_ec       <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_lp       <= n_lp;
            r_ec       <= n_ec;
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_kind <= n_s1_kind;
            r_s1_last <= n_s1_last;
            r_s1_pix  <= i_in.pixel;
            r_s1_cidx <= i_in.candidate_index;
        end
    end

    nnsd_ram #(
        .WIDTH (nnsd_pkg::PIXEL_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_query_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_lp[ADDR_W-1:0]),
        .i_wdata (i_in.pixel),
        .i_re    (ram_re),
        .i_raddr (r_ec[ADDR_W-1:0]),
        .o_rdata (qpix)
    );

    always_comb begin
        o_push           = r_s1_valid;
        o_push_data.kind = r_s1_kind;
        o_push_data.last = r_s1_last;
        o_push_data.cidx = r_s1_cidx;
        o_push_data.diff = (r_s1_pix >= qpix) ? (r_s1_pix - qpix) : (qpix - r_s1_pix);
    end

endmodule

// File: rtl/nnsd_back.sv
// Back section: square and accumulate, track the nearest candidate, register results.
module nnsd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_valid,
    input  nnsd_pkg::t_job                i_job,
    output logic                          o_pop,
    input  logic [nnsd_pkg::QIDX_W-1:0]   i_query_index,
    nnsd_out_if.source                    o_out
);

    localparam int DW = nnsd_pkg::DIST_W;
    localparam int IW = nnsd_pkg::CIDX_W;
    localparam int SQ_W = 2 * nnsd_pkg::PIXEL_W;

    logic [DW-1:0]  r_acc, n_acc;
    logic [DW-1:0]  r_best_d, n_best_d;
    logic [IW-1:0]  r_best_i, n_best_i;
    logic           r_found, n_found;
    logic           r_ov, n_ov;
    logic           load_out;
    logic [IW-1:0]  r_done_index;
    logic [DW-1:0]  r_distance;
    logic [DW-1:0]  r_out_best_d;
    logic [IW-1:0]  r_out_best_i;
    logic           r_out_found;

    logic [SQ_W-1:0] sq;
    logic [DW-1:0]   sum;

    assign o_pop = i_job_valid && (!r_ov || o_out.ready);
    assign sq    = SQ_W'(i_job.diff) * SQ_W'(i_job.diff);
    assign sum   = r_acc + DW'(sq);

    always_comb begin
        n_acc    = r_acc;
        n_best_d = r_best_d;
        n_best_i = r_best_i;
        n_found  = r_found;
        load_out = 1'b0;
        if (o_pop) begin
            unique case (i_job.kind)
                nnsd_pkg::JOB_CLEAR: begin
                    n_acc    = '0;
                    n_best_d = '1;
                    n_best_i = '0;
                    n_found  = 1'b0;
                end
                nnsd_pkg::JOB_CAND: begin
                    if (i_job.last) begin
                        n_acc    = '0;
                        load_out = 1'b1;
                        if (i_job.cidx != i_query_index) begin
                            if (!r_found || sum < r_best_d) begin
                                n_best_d = sum;
                                n_best_i = i_job.cidx;
                            end
                            n_found = 1'b1;
                        end
                    end else begin
                        n_acc = sum;
                    end
                end
            endcase
        end
    end

    always_comb begin
        n_ov = r_ov;
        if (load_out) begin
            n_ov = 1'b1;
        end else if (o_out.ready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_best_d <= '1;
            r_best_i <= '0;
            r_found  <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_acc    <= n_acc;
            r_best_d <= n_best_d;
            r_best_i <= n_best_i;
            r_found  <= n_found;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_done_index <= i_job.cidx;
            r_distance   <= sum;
            r_out_best_d <= n_best_d;
            r_out_best_i <= n_best_i;
            r_out_found  <= n_found;
        end
    end

    assign o_out.valid         = r_ov;
    assign o_out.done_index    = r_done_index;
    assign o_out.distance      = r_distance;
    assign o_out.best_distance = r_out_best_d;
    assign o_out.best_index    = r_out_best_i;
    assign o_out.found         = r_out_found;

endmodule

// File: rtl/nearest_neighbor_sq_distance.sv
// Top level: nearest-neighbor search by squared Euclidean distance over 8-bit pixels.
// Takes one item per clock cycle while the input is ready: query loads, candidate pixels and clears alike.
// Opcode 0 writes the next query pixel into the on-chip query store, opcode 1 adds
// one candidate pixel's squared difference to the running distance, opcode 2 clears
// the best match and the load and element counters, opcode 3 is dropped. A result
// transfer follows the last pixel of each candidate, through the fetch register and the
// job queue, when the output is free. The query store is a single RAM with one write and
// one registered read port, so a candidate pixel goes through a fetch register before it
// enters a QUEUE_DEPTH-entry job queue; the input stalls only when the queue and the
// fetch stage together hold QUEUE_DEPTH jobs because results are not taken. The query
// store holds no reset contents: load a whole query vector before streaming candidates.
module nearest_neighbor_sq_distance #(
    parameter int MAX_ELEMENTS = nnsd_pkg::MAX_ELEMENTS,
    parameter int QUEUE_DEPTH  = nnsd_pkg::QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    nnsd_in_if.sink                        i_in,
    nnsd_out_if.source                     o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [nnsd_pkg::PADDR_W-1:0]   paddr,
    input  logic [nnsd_pkg::PDATA_W-1:0]   pwdata,
    output logic [nnsd_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);

    localparam int CNT_W  = $clog2(MAX_ELEMENTS+1);
    localparam int VW     = nnsd_pkg::VLEN_W;
    localparam int LEN_W  = (CNT_W > VW) ? CNT_W : VW;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH+1);

    logic [VW-1:0]                  r_vector_length;
    logic [nnsd_pkg::QIDX_W-1:0]    r_query_index;
    logic                           cfg_write;
    logic [LEN_W-1:0]               vlen_wide;
    logic [LEN_W-1:0]               len_wide;
    logic [CNT_W-1:0]               len;

    logic                           push;
    nnsd_pkg::t_job                 push_data;
    logic                           pop;
    logic                           job_valid;
    nnsd_pkg::t_job                 job;
    logic [QCNT_W-1:0]              queue_count;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vector_length <= nnsd_pkg::VLEN_RESET;
            r_query_index   <= nnsd_pkg::QIDX_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == nnsd_pkg::REG_VECTOR_LENGTH) begin
                r_vector_length <= pwdata[VW-1:0];
            end else begin
                r_query_index <= pwdata[nnsd_pkg::QIDX_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == nnsd_pkg::REG_QUERY_INDEX) begin
            prdata = nnsd_pkg::PDATA_W'(r_query_index);
        end else begin
            prdata = nnsd_pkg::PDATA_W'(r_vector_length);
        end
    end

    assign vlen_wide = LEN_W'(r_vector_length);

    always_comb begin
        priority if (vlen_wide == '0) begin
            len_wide = LEN_W'(1);
        end else if (vlen_wide > LEN_W'(MAX_ELEMENTS)) begin
            len_wide = LEN_W'(MAX_ELEMENTS);
        end else begin
            len_wide = vlen_wide;
        end
    end

    assign len = len_wide[CNT_W-1:0];

    nnsd_front #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .QUEUE_DEPTH  (QUEUE_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_len         (len),
        .i_queue_count (queue_count),
        .o_push        (push),
        .o_push_data   (push_data)
    );

    nnsd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_valid     (job_valid),
        .o_head      (job),
        .o_count     (queue_count)
    );

    nnsd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (job_valid),
        .i_job         (job),
        .o_pop         (pop),
        .i_query_index (r_query_index),
        .o_out         (o_out)
    );

`ifndef NO_ASSERTIONS
    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |-> queue_count < QCNT_W'(QUEUE_DEPTH))
        else $error("job queue overflow");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> job_valid)
        else $error("job popped from empty queue");

    a_not_found_best_inf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.found |-> o_out.best_distance == '1)
        else $error("best distance set without a match");

    a_best_not_above: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.done_index != r_query_index
        |-> o_out.found && o_out.best_distance <= o_out.distance)
        else $error("best distance above a completed candidate");
`endif

endmodule
